// ----- hw/rtl/glzw_pkg.sv -----
// Shared types, constants and helper functions of the GIF LZW code packer.
package glzw_pkg;

  // Dictionary geometry and code limits
  localparam int HASH_SLOTS    = 5003;
  localparam int MAX_CODE_BITS = 12;
  localparam int IDX_W         = $clog2(HASH_SLOTS);
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int NF_W          = CODE_W + 1;
  localparam int PIX_W         = 8;
  localparam int KEY_W         = PIX_W + CODE_W;
  localparam int CW_W          = 4;
  localparam int BUF_W         = 24;
  localparam int CNT_W         = 5;
  localparam int RAM_W         = 1 + KEY_W + CODE_W;

  // Shift that spreads the pixel over the hash index
  function automatic int hash_shift_f();
    int f;
    int s;
    f = HASH_SLOTS;
    s = 0;
    while (f < 65536) begin
      f = f * 2;
      s = s + 1;
    end
    return 8 - s;
  endfunction

  localparam int HASH_SHIFT = hash_shift_f();

  // Code selection for the packer
  localparam logic [1:0] SEL_PFX = 2'd0;
  localparam logic [1:0] SEL_CLR = 2'd1;
  localparam logic [1:0] SEL_END = 2'd2;

  // Register index of the config port
  localparam logic REG_CODE_SIZE = 1'b0;

  // Highest code value at the given width before the width grows
  function automatic logic [NF_W-1:0] limit_for(logic [CW_W-1:0] bits);
    if (bits >= CW_W'(MAX_CODE_BITS)) begin
      return NF_W'(1) << MAX_CODE_BITS;
    end
    return (NF_W'(1) << bits) - NF_W'(1);
  endfunction

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } glzw_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       image_end;
  } glzw_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       start_image;
    logic       start_lookup;
    logic       clr_wr;
    logic       chk;
    logic       hit;
    logic       probe_step;
    logic       put;
    logic [1:0] put_sel;
    logic       emit;
    logic       pad;
    logic       pad_zero;
    logic       width_upd;
    logic       insert;
    logic       finish;
  } glzw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_image;
    logic last;
    logic clr_done;
    logic chk_hit;
    logic chk_empty;
    logic exhausted;
    logic cnt_ge8;
    logic cnt_nz;
    logic table_full;
    logic pend_valid;
    logic out_free;
  } glzw_sts_t;

endpackage

// ----- hw/rtl/glzw_ram.sv -----
// Generic single-port RAM with registered read.
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/glzw_ctrl.sv -----
// Sequencer of the LZW packer: lookup, code packing, clearing and flush.
module glzw_ctrl import glzw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  glzw_sts_t sts_i,
  output glzw_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_CHK   = 4'd3;
  localparam logic [3:0] ST_PPFX  = 4'd4;
  localparam logic [3:0] ST_INS   = 4'd5;
  localparam logic [3:0] ST_PCLR  = 4'd6;
  localparam logic [3:0] ST_LPFX  = 4'd7;
  localparam logic [3:0] ST_LEND  = 4'd8;
  localparam logic [3:0] ST_PAD   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;
  localparam logic [3:0] ST_DRAIN = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic       sink_ok;
  logic [3:0] after_code;

  assign sink_ok    = !sts_i.pend_valid || sts_i.out_free;
  assign after_code = sts_i.last ? ST_LPFX : ST_DONE;
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!sts_i.in_image) begin
            cmd_o.start_image = 1'b1;
            state_d = ST_CLR;
          end else begin
            cmd_o.start_lookup = 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_PCLR;
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.chk_hit) begin
          cmd_o.hit = 1'b1;
          state_d = after_code;
        end else if (sts_i.chk_empty || sts_i.exhausted) begin
          state_d = ST_PPFX;
        end else begin
          cmd_o.probe_step = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_PPFX: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = SEL_PFX;
        ret_d   = ST_INS;
        state_d = ST_DRAIN;
      end
      ST_INS: begin
        cmd_o.insert = 1'b1;
        state_d = sts_i.table_full ? ST_CLR : after_code;
      end
      ST_PCLR: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = SEL_CLR;
        ret_d   = after_code;
        state_d = ST_DRAIN;
      end
      ST_LPFX: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = SEL_PFX;
        ret_d   = ST_LEND;
        state_d = ST_DRAIN;
      end
      ST_LEND: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = SEL_END;
        ret_d   = ST_PAD;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.cnt_ge8) begin
          cmd_o.emit = sink_ok;
        end else begin
          cmd_o.width_upd = 1'b1;
          state_d = ret_q;
        end
      end
      ST_PAD: begin
        if (sts_i.cnt_nz) begin
          cmd_o.emit = sink_ok;
          cmd_o.pad  = 1'b1;
        end else begin
          cmd_o.pad_zero = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sink_ok) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

// ----- hw/rtl/glzw_dpath.sv -----
// Datapath of the LZW packer: dictionary, code state, bit buffer and output beat.
module glzw_dpath import glzw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  glzw_in_t        in_data_i,
  input  logic [CW_W-1:0] code_size_i,
  input  glzw_cmd_t       cmd_i,
  output glzw_sts_t       sts_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output glzw_out_t       out_data_o
);

  logic [PIX_W-1:0]  pixel_q;
  logic              last_q;
  logic              in_image_q;
  logic [CODE_W-1:0] prefix_q;
  logic [NF_W-1:0]   nf_q;
  logic [CW_W-1:0]   cw_q;
  logic [CW_W-1:0]   base_q;
  logic [NF_W-1:0]   wl_q;
  logic [BUF_W-1:0]  buf_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              cp_q;
  logic [IDX_W-1:0]  idx_q, disp_q, probe_q, clr_q;
  logic              empty_q;
  logic [7:0]        pend_q;
  logic              pend_v_q;
  glzw_out_t         out_q;
  logic              out_v_q;

  // Dictionary RAM: {valid, key, code}
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key, key;
  logic [CODE_W-1:0] rd_code;

  assign key = {pixel_q, prefix_q};
  assign {rd_valid, rd_key, rd_code} = ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = {1'b1, key, nf_q[CODE_W-1:0]};
    if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.insert && !nf_q[CODE_W] && empty_q) begin
      ram_we = 1'b1;
    end
  end

  glzw_ram #(.WIDTH(RAM_W), .DEPTH(HASH_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Hash of the incoming pixel and first probe displacement
  logic [31:0]      hash_raw, hash_red;
  logic [IDX_W-1:0] idx0, disp0, idx_step;

  assign hash_raw = (32'(in_data_i.pixel) << HASH_SHIFT) ^ 32'(prefix_q);
  assign hash_red = (hash_raw >= 32'(HASH_SLOTS)) ? hash_raw - 32'(HASH_SLOTS) : hash_raw;
  assign idx0     = hash_red[IDX_W-1:0];
  assign disp0    = (idx0 == '0) ? IDX_W'(1) : IDX_W'(HASH_SLOTS) - idx0;
  assign idx_step = (idx_q >= disp_q) ? idx_q - disp_q
                                      : idx_q + (IDX_W'(HASH_SLOTS) - disp_q);

  // Clamped code size for a new image
  logic [CW_W-1:0]   cs_clamp, base_new;
  logic [CODE_W-1:0] clear_code, put_code, code_mask;

  always_comb begin
    cs_clamp = code_size_i;
    if (code_size_i < CW_W'(2)) begin
      cs_clamp = CW_W'(2);
    end else if (code_size_i > CW_W'(MAX_CODE_BITS - 1)) begin
      cs_clamp = CW_W'(MAX_CODE_BITS - 1);
    end
  end
  assign base_new   = cs_clamp + CW_W'(1);
  assign clear_code = CODE_W'(1) << (base_q - CW_W'(1));

  // Code to pack, masked to the current width
  always_comb begin
    case (cmd_i.put_sel)
      SEL_CLR: put_code = clear_code;
      SEL_END: put_code = clear_code + CODE_W'(1);
      default: put_code = prefix_q;
    endcase
  end
  assign code_mask = CODE_W'((NF_W'(1) << cw_q) - NF_W'(1));

  logic out_take;
  logic out_load;
  assign out_take = out_v_q && !out_stall_i;
  assign out_load = (cmd_i.emit || cmd_i.finish) && pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q    <= '0;
      last_q     <= 1'b0;
      in_image_q <= 1'b0;
      prefix_q   <= '0;
      nf_q       <= '0;
      cw_q       <= '0;
      base_q     <= '0;
      wl_q       <= '0;
      buf_q      <= '0;
      cnt_q      <= '0;
      cp_q       <= 1'b0;
      idx_q      <= '0;
      disp_q     <= '0;
      probe_q    <= '0;
      clr_q      <= '0;
      empty_q    <= 1'b0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      out_q      <= '0;
      out_v_q    <= 1'b0;
    end else begin
      // Output beat valid: loaded from the pending byte or taken by the sink
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
      // New image: latch widths and start the clearing pass
      if (cmd_i.start_image) begin
        pixel_q    <= in_data_i.pixel;
        last_q     <= in_data_i.last_pixel;
        in_image_q <= 1'b1;
        base_q     <= base_new;
        cw_q       <= base_new;
        wl_q       <= limit_for(base_new);
        nf_q       <= (NF_W'(1) << cs_clamp) + NF_W'(2);
        cp_q       <= 1'b0;
        buf_q      <= '0;
        cnt_q      <= '0;
        prefix_q   <= CODE_W'(in_data_i.pixel);
        clr_q      <= '0;
      end
      // Next pixel: first probe position
      if (cmd_i.start_lookup) begin
        pixel_q <= in_data_i.pixel;
        last_q  <= in_data_i.last_pixel;
        idx_q   <= idx0;
        disp_q  <= disp0;
        probe_q <= '0;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.chk) begin
        empty_q <= !rd_valid;
      end
      if (cmd_i.hit) begin
        prefix_q <= rd_code;
      end
      if (cmd_i.probe_step) begin
        idx_q   <= idx_step;
        probe_q <= probe_q + IDX_W'(1);
      end
      // Pack one code into the bit buffer
      if (cmd_i.put) begin
        buf_q <= buf_q | (BUF_W'(put_code & code_mask) << cnt_q);
        cnt_q <= cnt_q + CNT_W'(cw_q);
      end
      // One byte out of the bit buffer into the pending beat
      if (cmd_i.emit) begin
        buf_q <= buf_q >> 8;
        if (cmd_i.pad) begin
          cnt_q <= (cnt_q > CNT_W'(8)) ? cnt_q - CNT_W'(8) : '0;
        end else begin
          cnt_q <= cnt_q - CNT_W'(8);
        end
        pend_q   <= buf_q[7:0];
        pend_v_q <= 1'b1;
        if (pend_v_q) begin
          out_q <= '{out_byte: pend_q, run_last: 1'b0, image_end: 1'b0};
        end
      end
      if (cmd_i.pad_zero) begin
        buf_q <= '0;
      end
      // Width growth or reset after a clear
      if (cmd_i.width_upd && (nf_q > wl_q || cp_q)) begin
        if (cp_q) begin
          cw_q <= base_q;
          wl_q <= limit_for(base_q);
          cp_q <= 1'b0;
        end else if (cw_q < CW_W'(MAX_CODE_BITS)) begin
          cw_q <= cw_q + CW_W'(1);
          wl_q <= limit_for(cw_q + CW_W'(1));
        end
      end
      // Enter the new string, or start over when the table is full
      if (cmd_i.insert) begin
        prefix_q <= CODE_W'(pixel_q);
        if (!nf_q[CODE_W]) begin
          if (empty_q) begin
            nf_q <= nf_q + NF_W'(1);
          end
        end else begin
          nf_q  <= NF_W'(clear_code) + NF_W'(2);
          cp_q  <= 1'b1;
          clr_q <= '0;
        end
      end
      // End of pixel: last pending beat carries the flags
      if (cmd_i.finish) begin
        if (last_q) begin
          in_image_q <= 1'b0;
        end
        if (pend_v_q) begin
          out_q    <= '{out_byte: pend_q, run_last: 1'b1, image_end: last_q};
          pend_v_q <= 1'b0;
        end
      end
    end
  end

  // Status
  always_comb begin
    sts_o            = '0;
    sts_o.in_image   = in_image_q;
    sts_o.last       = last_q;
    sts_o.clr_done   = (clr_q == IDX_W'(HASH_SLOTS - 1));
    sts_o.chk_hit    = rd_valid && (rd_key == key);
    sts_o.chk_empty  = !rd_valid;
    sts_o.exhausted  = (probe_q == IDX_W'(HASH_SLOTS));
    sts_o.cnt_ge8    = (cnt_q >= CNT_W'(8));
    sts_o.cnt_nz     = (cnt_q != '0);
    sts_o.table_full = nf_q[CODE_W];
    sts_o.pend_valid = pend_v_q;
    sts_o.out_free   = !out_v_q || !out_stall_i;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/gif_lzw_code_packer.sv -----
// Top level of the GIF LZW code packer: config register, controller and datapath.
// One pixel beat at a time is taken. A pixel that continues the current string
// takes one dictionary RAM read and one compare per hash probe; a pixel that
// emits a code also packs it into the bit buffer and sends out each completed
// output byte. The first pixel of an image, and a pixel that finds the code
// table full, run a clearing pass over all 5003 slots of the dictionary RAM
// during which no pixel is taken. Output beats leave through a one-entry output
// register; the final beat of each pixel has run_last set, and the final beat of
// the image also has image_end set. code_size is latched at the first pixel.
module gif_lzw_code_packer import glzw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  glzw_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output glzw_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CW_W-1:0] code_size_q;
  glzw_cmd_t       cmd;
  glzw_sts_t       sts;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_size_q <= CW_W'(8);
    end else if (psel && penable && pwrite && (paddr[2] == REG_CODE_SIZE)) begin
      code_size_q <= pwdata[CW_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CODE_SIZE) ? 32'(code_size_q) : '0;

  glzw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glzw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .code_size_i (code_size_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the GIF LZW code packer: pixel beats in, packed bytes checked.
module tb_top;
  import glzw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  glzw_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  glzw_out_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [2:0] ADDR_CODE_SIZE = 3'(4 * REG_CODE_SIZE);

  gif_lzw_code_packer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Expected output bytes, oldest first
  glzw_out_t exp_bytes[$];
  int        mismatches = 0;
  bit        calm = 0;

  // Shadow dictionary and packer state
  bit [KEY_W-1:0]  dict_key   [HASH_SLOTS];
  bit              dict_used  [HASH_SLOTS];
  bit [CODE_W-1:0] dict_code  [HASH_SLOTS];
  int              cur_prefix;
  int              free_code;
  int              cur_width;
  int              grow_at;
  int              start_width;
  int              acc_bits;
  int              acc_cnt;
  bit              reset_width;
  bit              mid_image;
  bit [3:0]        depth_reg = 4'd8;
  bit [7:0]        step_bytes[$];

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #15ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int width_cap(int bits);
    if (bits >= MAX_CODE_BITS) return 1 << MAX_CODE_BITS;
    return (1 << bits) - 1;
  endfunction

  function automatic void wipe_dict();
    foreach (dict_used[k]) dict_used[k] = 1'b0;
  endfunction

  // Pack one code at the current width, then grow or reset the width
  function automatic void pack_code(int code);
    acc_bits = acc_bits | ((code & ((1 << cur_width) - 1)) << acc_cnt);
    acc_cnt += cur_width;
    while (acc_cnt >= 8) begin
      step_bytes.push_back(acc_bits[7:0]);
      acc_bits = acc_bits >> 8;
      acc_cnt -= 8;
    end
    if (free_code > grow_at || reset_width) begin
      if (reset_width) begin
        cur_width   = start_width;
        grow_at     = width_cap(cur_width);
        reset_width = 1'b0;
      end else if (cur_width < MAX_CODE_BITS) begin
        cur_width++;
        grow_at = width_cap(cur_width);
      end
    end
  endfunction

  // Compress one pixel and queue the bytes it completes
  function automatic void lzw_predict(bit [7:0] pix, bit last);
    int clr, depth, key, idx, disp, probes;
    bit hit, empty;
    glzw_out_t b;
    step_bytes.delete();
    if (!mid_image) begin
      depth = int'(depth_reg);
      if (depth < 2) depth = 2;
      if (depth > MAX_CODE_BITS - 1) depth = MAX_CODE_BITS - 1;
      mid_image   = 1'b1;
      start_width = depth + 1;
      cur_width   = start_width;
      grow_at     = width_cap(cur_width);
      clr         = 1 << depth;
      free_code   = clr + 2;
      reset_width = 1'b0;
      wipe_dict();
      acc_bits    = 0;
      acc_cnt     = 0;
      cur_prefix  = int'(pix);
      pack_code(clr);
    end else begin
      clr   = 1 << (start_width - 1);
      key   = (int'(pix) << MAX_CODE_BITS) + cur_prefix;
      idx   = (int'(pix) << HASH_SHIFT) ^ cur_prefix;
      hit   = 1'b0;
      empty = 1'b0;
      if (idx >= HASH_SLOTS) idx -= HASH_SLOTS;
      if (dict_used[idx] && dict_key[idx] == key) begin
        hit = 1'b1;
      end else if (!dict_used[idx]) begin
        empty = 1'b1;
      end else begin
        // secondary probing walks down by a fixed displacement
        disp   = (idx == 0) ? 1 : HASH_SLOTS - idx;
        probes = 0;
        while (probes < HASH_SLOTS) begin
          probes++;
          idx -= disp;
          if (idx < 0) idx += HASH_SLOTS;
          if (!dict_used[idx]) begin
            empty = 1'b1;
            break;
          end
          if (dict_key[idx] == key) begin
            hit = 1'b1;
            break;
          end
        end
      end
      if (hit) begin
        cur_prefix = int'(dict_code[idx]);
      end else begin
        pack_code(cur_prefix);
        cur_prefix = int'(pix);
        if (free_code < (1 << MAX_CODE_BITS)) begin
          if (empty) begin
            dict_code[idx] = CODE_W'(free_code);
            dict_key[idx]  = KEY_W'(key);
            dict_used[idx] = 1'b1;
            free_code++;
          end
        end else begin
          // table full: clear code and start over
          wipe_dict();
          free_code   = clr + 2;
          reset_width = 1'b1;
          pack_code(clr);
        end
      end
    end
    if (last) begin
      pack_code(cur_prefix);
      pack_code(clr + 1);
      while (acc_cnt > 0) begin
        step_bytes.push_back(acc_bits[7:0]);
        acc_bits = acc_bits >> 8;
        acc_cnt  = (acc_cnt > 8) ? acc_cnt - 8 : 0;
      end
      acc_bits  = 0;
      mid_image = 1'b0;
    end
    foreach (step_bytes[k]) begin
      b.out_byte  = step_bytes[k];
      b.run_last  = (k == step_bytes.size() - 1);
      b.image_end = b.run_last && last;
      exp_bytes.push_back(b);
    end
  endfunction

  // Receiver stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    if (!calm && stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Byte checker: a beat visible at the falling edge is taken at the next rising edge
  always @(negedge clk_i) begin
    glzw_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_bytes.size() == 0) begin
        $display("%0t: unexpected byte, exp none got %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = exp_bytes.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $display("%0t: out_byte exp %h got %h", $time, want.out_byte, out_data_o.out_byte);
          mismatches++;
        end
        if (out_data_o.run_last !== want.run_last) begin
          $display("%0t: run_last exp %b got %b", $time, want.run_last, out_data_o.run_last);
          mismatches++;
        end
        if (out_data_o.image_end !== want.image_end) begin
          $display("%0t: image_end exp %b got %b", $time, want.image_end,
                   out_data_o.image_end);
          mismatches++;
        end
      end
    end
  end

  // Send one pixel beat; called at a rising edge
  task automatic send_pixel(bit [7:0] pix, bit last);
    bit taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel: pix, last_pixel: last};
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    lzw_predict(pix, last);
  endtask

  // Wait for every expected byte plus a margin for work that makes no byte
  task automatic drain();
    in_valid_i <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_depth(bit [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CODE_SIZE;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    depth_reg = val;
    @(posedge clk_i);
  endtask

  // Extreme pixel values at full depth, including a repeated pair
  task automatic test_extremes();
    write_depth(4'd8);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd85, 1'b1);
    drain();
  endtask

  // Smallest depth (clamped up), pixels above depth, one-pixel image
  task automatic test_low_depth();
    write_depth(4'd1);
    send_pixel(8'd3, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd2, 1'b0);
    send_pixel(8'd3, 1'b1);
    drain();
  endtask

  // Long run of one value: dictionary hits and width growth
  task automatic test_runs();
    write_depth(4'd2);
    for (int k = 0; k < 10; k++) send_pixel(8'd1, k == 9);
    drain();
  endtask

  // Many fresh strings at full depth: the code width grows past its start
  task automatic test_width_growth();
    write_depth(4'd8);
    for (int k = 0; k < 280; k++) send_pixel(8'($urandom_range(0, 255)), k == 279);
    drain();
  endtask

  // Random images over random depths
  task automatic test_random_images();
    int sent, len, lim, paused;
    sent   = 0;
    paused = 0;
    while (sent < 150) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_depth(4'($urandom_range(1, 8)));
      end
      if (!paused && sent > 60) begin
        drain();
        paused = 1;
      end
      if (sent > 110) calm = 1;
      len = $urandom_range(1, 50);
      lim = (1 << ((depth_reg < 2) ? 2 : depth_reg)) - 1;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 15) == 0) send_pixel(8'($urandom), k == len - 1);
        else if ($urandom_range(0, 2) == 0) send_pixel(8'($urandom_range(0, 1)), k == len - 1);
        else send_pixel(8'($urandom_range(0, lim)), k == len - 1);
      end
      sent += len;
    end
    drain();
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    test_extremes();
    test_low_depth();
    test_runs();
    test_width_growth();
    test_random_images();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && exp_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
